@@ rtl/core/cvxh_pkg.sv @@
// Shared types, constants and state codes of the gift-wrapping hull core.
package cvxh_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 16;
  localparam int PT_W       = 2 * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] MIN_HULL_PTS = CNT_W'(3);

  localparam logic [1:0] KIND_HULL     = 2'd0;
  localparam logic [1:0] KIND_INTERIOR = 2'd1;
  localparam logic [1:0] KIND_TOO_FEW  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic [1:0]                point_kind;
    logic                      end_of_run;
  } out_item_t;

  // sequencer -> result stage
  typedef struct packed {
    logic      push;
    logic      fin;
    out_item_t item;
  } out_cmd_t;

  // result stage -> sequencer
  typedef struct packed {
    logic can_push;
    logic can_fin;
    logic pend_vld;
  } out_sts_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FEW,
    ST_FLUSH,
    ST_LEFT,
    ST_REC,
    ST_QCAP,
    ST_SC_MUL,
    ST_SC_CMP,
    ST_NEXT,
    ST_H_RD,
    ST_H_PUSH,
    ST_I_RD,
    ST_I_CAP,
    ST_I_CMP
  } state_t;

endpackage

@@ rtl/core/cvxh_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
module cvxh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/cvxh_orient.sv @@
// Orientation test of (p, i, q): registered cross-product terms, then sign compare.
module cvxh_orient (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cvxh_pkg::COORD_W-1:0] px,
  input  logic signed [cvxh_pkg::COORD_W-1:0] py,
  input  logic signed [cvxh_pkg::COORD_W-1:0] ix,
  input  logic signed [cvxh_pkg::COORD_W-1:0] iy,
  input  logic signed [cvxh_pkg::COORD_W-1:0] qx,
  input  logic signed [cvxh_pkg::COORD_W-1:0] qy,
  output logic                               ccw
);

  logic signed [cvxh_pkg::DIFF_W-1:0] d_iy_py, d_qx_ix, d_ix_px, d_qy_iy;
  logic signed [cvxh_pkg::PROD_W-1:0] prod_a_nxt, prod_b_nxt;
  logic signed [cvxh_pkg::PROD_W-1:0] prod_a_r, prod_b_r;

  always_comb begin
    d_iy_py    = $signed({iy[cvxh_pkg::COORD_W-1], iy}) - $signed({py[cvxh_pkg::COORD_W-1], py});
    d_qx_ix    = $signed({qx[cvxh_pkg::COORD_W-1], qx}) - $signed({ix[cvxh_pkg::COORD_W-1], ix});
    d_ix_px    = $signed({ix[cvxh_pkg::COORD_W-1], ix}) - $signed({px[cvxh_pkg::COORD_W-1], px});
    d_qy_iy    = $signed({qy[cvxh_pkg::COORD_W-1], qy}) - $signed({iy[cvxh_pkg::COORD_W-1], iy});
    prod_a_nxt = d_iy_py * d_qx_ix;
    prod_b_nxt = d_ix_px * d_qy_iy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
    end
  end

  // cross = a - b; negative means counter-clockwise
  assign ccw = prod_a_r < prod_b_r;

endmodule

@@ rtl/core/cvxh_out.sv @@
// Result stage: one-word hold-back register (to tag the last word) and output register.
module cvxh_out (
  input  logic                clk,
  input  logic                rst_n,
  input  cvxh_pkg::out_cmd_t  cmd,
  output cvxh_pkg::out_sts_t  sts,
  output logic                out_valid,
  input  logic                out_ready,
  output cvxh_pkg::out_item_t out_data
);

  cvxh_pkg::out_item_t pend_r, out_r;
  cvxh_pkg::out_item_t fin_item;
  logic                pend_vld_r, out_vld_r;
  logic                out_free;

  assign out_free     = !out_vld_r || out_ready;
  assign sts.can_push = !pend_vld_r || out_free;
  assign sts.can_fin  = out_free;
  assign sts.pend_vld = pend_vld_r;

  // held word with the end-of-run tag set
  always_comb begin
    fin_item            = pend_r;
    fin_item.end_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (cmd.push && sts.can_push) begin
      if (pend_vld_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      pend_vld_r <= 1'b1;
    end else if (cmd.fin && out_free) begin
      out_vld_r  <= pend_vld_r;
      pend_vld_r <= 1'b0;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && sts.can_push) begin
      if (pend_vld_r) begin
        out_r <= pend_r;
      end
      pend_r <= cmd.item;
    end else if (cmd.fin && out_free) begin
      out_r <= fin_item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/convex_hull_gift_wrap_core.sv @@
// Convex hull core (gift wrapping): point loader, hull walk sequencer and result emitter.
//
// Usage: points come in one word per cycle and are written to a 64-entry point RAM
// (extra points past 64 are dropped). The word with last_point set closes the set;
// in_ready then stays low until the last result word has moved into the output
// register. Results are the hull vertices in walk order (start = leftmost point,
// first in load order on ties), then every point matching no hull vertex, tagged
// interior, at most 64 words per set; end_of_run marks the last one. Fewer than
// three points give a single too-few word at (0,0). The leftmost scan reads every point
// once; in the walk every candidate takes a RAM read plus an orientation test on the
// registered cross-product terms, and the interior check streams the hull RAM once per
// point. Each RAM has a single read port. Both RAMs need no clearing after reset.
module convex_hull_gift_wrap_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cvxh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cvxh_pkg::out_item_t out_data
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  cvxh_pkg::state_t state_r, state_nxt;

  logic [cvxh_pkg::CNT_W-1:0] cnt_r;   // points loaded in the open set
  logic [cvxh_pkg::CNT_W-1:0] n_r;     // size of the closed set
  logic [cvxh_pkg::CNT_W-1:0] idx_r;   // point scan counter
  logic [cvxh_pkg::CNT_W-1:0] jdx_r;   // hull RAM scan counter
  logic [cvxh_pkg::CNT_W-1:0] hlen_r;  // hull vertices recorded
  logic [cvxh_pkg::CNT_W-1:0] k_r;     // result words produced
  logic                       rd_vld_r;
  logic [cvxh_pkg::IDX_W-1:0] rd_idx_r;
  logic [cvxh_pkg::IDX_W-1:0] pidx_r, qidx_r, iidx_r, start_r;
  logic signed [cvxh_pkg::COORD_W-1:0] px_r, py_r, qx_r, qy_r, ix_r, iy_r, cx_r, cy_r;
  logic                       hit_r;

  // ---------------------------------------------------------------------------
  // RAM ports and unit hookup
  // ---------------------------------------------------------------------------
  logic                       st_we, st_re, hl_we, hl_re;
  logic [cvxh_pkg::IDX_W-1:0] st_waddr, st_raddr, hl_waddr, hl_raddr;
  logic [cvxh_pkg::PT_W-1:0]  st_wdata, st_rdata, hl_wdata, hl_rdata;
  logic signed [cvxh_pkg::COORD_W-1:0] st_x, st_y;
  logic                       or_en, ccw;
  cvxh_pkg::out_cmd_t         out_cmd;
  cvxh_pkg::out_sts_t         out_sts;

  assign st_x = st_rdata[cvxh_pkg::PT_W-1:cvxh_pkg::COORD_W];
  assign st_y = st_rdata[cvxh_pkg::COORD_W-1:0];

  // point store, {x, y} per entry
  cvxh_ram #(.WIDTH(cvxh_pkg::PT_W), .DEPTH(cvxh_pkg::MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // hull vertices in walk order, kept as coordinates so emission and the
  // interior match need no second lookup
  cvxh_ram #(.WIDTH(cvxh_pkg::PT_W), .DEPTH(cvxh_pkg::MAX_POINTS)) u_hull_ram (
    .clk   (clk),
    .we    (hl_we),
    .waddr (hl_waddr),
    .wdata (hl_wdata),
    .re    (hl_re),
    .raddr (hl_raddr),
    .rdata (hl_rdata)
  );

  cvxh_orient u_orient (
    .clk (clk),
    .en  (or_en),
    .px  (px_r),
    .py  (py_r),
    .ix  (st_x),
    .iy  (st_y),
    .qx  (qx_r),
    .qy  (qy_r),
    .ccw (ccw)
  );

  cvxh_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (out_cmd),
    .sts       (out_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Helper terms
  // ---------------------------------------------------------------------------
  logic                       cnt_room, load_last, left_issue, cand_last, hull_last;
  logic                       int_done, walk_more, hull_hit, hit_any, push_ok;
  logic [cvxh_pkg::CNT_W-1:0] n_tot, idx_inc, jdx_inc, q_inc;
  logic [cvxh_pkg::IDX_W-1:0] q_start;

  always_comb begin
    cnt_room   = cnt_r < cvxh_pkg::MAX_CNT;
    load_last  = in_valid && in_data.last_point;
    n_tot      = cnt_r + cvxh_pkg::CNT_W'(cnt_room);
    left_issue = idx_r < n_r;
    idx_inc    = idx_r + 1'b1;
    cand_last  = idx_inc == n_r;
    jdx_inc    = jdx_r + 1'b1;
    hull_last  = jdx_inc == hlen_r;
    // first candidate is the successor of p, wrapping at n
    q_inc      = {1'b0, pidx_r} + 1'b1;
    q_start    = (q_inc == n_r) ? '0 : q_inc[cvxh_pkg::IDX_W-1:0];
    int_done   = (idx_r == n_r) || (k_r == cvxh_pkg::MAX_CNT);
    walk_more  = (qidx_r != start_r) && (hlen_r < cvxh_pkg::MAX_CNT);
    hull_hit   = hl_rdata == {cx_r, cy_r};
    hit_any    = hit_r || hull_hit;
    push_ok    = out_cmd.push && out_sts.can_push;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cvxh_pkg::ST_LOAD: begin
        if (load_last) begin
          state_nxt = (n_tot < cvxh_pkg::MIN_HULL_PTS) ? cvxh_pkg::ST_FEW : cvxh_pkg::ST_LEFT;
        end
      end
      cvxh_pkg::ST_FEW: begin
        if (out_sts.can_push) state_nxt = cvxh_pkg::ST_FLUSH;
      end
      cvxh_pkg::ST_FLUSH: begin
        if (out_sts.can_fin) state_nxt = cvxh_pkg::ST_LOAD;
      end
      cvxh_pkg::ST_LEFT: begin
        if (!left_issue && !rd_vld_r) state_nxt = cvxh_pkg::ST_REC;
      end
      cvxh_pkg::ST_REC:    state_nxt = cvxh_pkg::ST_QCAP;
      cvxh_pkg::ST_QCAP:   state_nxt = cvxh_pkg::ST_SC_MUL;
      cvxh_pkg::ST_SC_MUL: state_nxt = cvxh_pkg::ST_SC_CMP;
      cvxh_pkg::ST_SC_CMP: begin
        state_nxt = cand_last ? cvxh_pkg::ST_NEXT : cvxh_pkg::ST_SC_MUL;
      end
      cvxh_pkg::ST_NEXT: begin
        state_nxt = walk_more ? cvxh_pkg::ST_REC : cvxh_pkg::ST_H_RD;
      end
      cvxh_pkg::ST_H_RD:   state_nxt = cvxh_pkg::ST_H_PUSH;
      cvxh_pkg::ST_H_PUSH: begin
        if (out_sts.can_push && hull_last) state_nxt = cvxh_pkg::ST_I_RD;
      end
      cvxh_pkg::ST_I_RD: begin
        state_nxt = int_done ? cvxh_pkg::ST_FLUSH : cvxh_pkg::ST_I_CAP;
      end
      cvxh_pkg::ST_I_CAP:  state_nxt = cvxh_pkg::ST_I_CMP;
      cvxh_pkg::ST_I_CMP: begin
        if (hull_last && (hit_any || out_sts.can_push)) state_nxt = cvxh_pkg::ST_I_RD;
      end
      default:             state_nxt = cvxh_pkg::ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: RAM strobes, result commands, input ready
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    st_we    = 1'b0;
    st_waddr = cnt_r[cvxh_pkg::IDX_W-1:0];
    st_wdata = {in_data.point_x, in_data.point_y};
    st_re    = 1'b0;
    st_raddr = idx_r[cvxh_pkg::IDX_W-1:0];
    hl_we    = 1'b0;
    hl_waddr = hlen_r[cvxh_pkg::IDX_W-1:0];
    hl_wdata = {px_r, py_r};
    hl_re    = 1'b0;
    hl_raddr = jdx_r[cvxh_pkg::IDX_W-1:0];
    or_en    = 1'b0;
    out_cmd  = '0;
    unique case (state_r)
      cvxh_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        st_we    = in_valid && cnt_room;
      end
      cvxh_pkg::ST_FEW: begin
        out_cmd.push            = 1'b1;
        out_cmd.item.point_kind = cvxh_pkg::KIND_TOO_FEW;
      end
      cvxh_pkg::ST_FLUSH: out_cmd.fin = 1'b1;
      cvxh_pkg::ST_LEFT:  st_re = left_issue;
      cvxh_pkg::ST_REC: begin
        hl_we    = 1'b1;
        st_re    = 1'b1;
        st_raddr = q_start;
      end
      cvxh_pkg::ST_QCAP: begin
        st_re    = 1'b1;
        st_raddr = '0;
      end
      cvxh_pkg::ST_SC_MUL: or_en = 1'b1;
      cvxh_pkg::ST_SC_CMP: begin
        // read of the next candidate overlaps the compare
        st_re    = !cand_last;
        st_raddr = idx_inc[cvxh_pkg::IDX_W-1:0];
      end
      cvxh_pkg::ST_NEXT: ;
      cvxh_pkg::ST_H_RD: hl_re = 1'b1;
      cvxh_pkg::ST_H_PUSH: begin
        out_cmd.push            = 1'b1;
        out_cmd.item.vert_x     = hl_rdata[cvxh_pkg::PT_W-1:cvxh_pkg::COORD_W];
        out_cmd.item.vert_y     = hl_rdata[cvxh_pkg::COORD_W-1:0];
        out_cmd.item.point_kind = cvxh_pkg::KIND_HULL;
        // RAM data must hold while the result stage stalls
        hl_re    = out_sts.can_push && !hull_last;
        hl_raddr = jdx_inc[cvxh_pkg::IDX_W-1:0];
      end
      cvxh_pkg::ST_I_RD: st_re = !int_done;
      cvxh_pkg::ST_I_CAP: begin
        hl_re    = 1'b1;
        hl_raddr = '0;
      end
      cvxh_pkg::ST_I_CMP: begin
        hl_re                   = !hull_last;
        hl_raddr                = jdx_inc[cvxh_pkg::IDX_W-1:0];
        out_cmd.push            = hull_last && !hit_any;
        out_cmd.item.vert_x     = cx_r;
        out_cmd.item.vert_y     = cy_r;
        out_cmd.item.point_kind = cvxh_pkg::KIND_INTERIOR;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cvxh_pkg::ST_LOAD;
      cnt_r    <= '0;
      hlen_r   <= '0;
      k_r      <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == cvxh_pkg::ST_LEFT) && left_issue;
      if (state_r == cvxh_pkg::ST_LOAD && in_valid) begin
        cnt_r <= load_last ? '0 : n_tot;
      end
      if (state_r == cvxh_pkg::ST_LOAD && load_last) begin
        hlen_r <= '0;
      end else if (state_r == cvxh_pkg::ST_REC) begin
        hlen_r <= hlen_r + 1'b1;
      end
      if (state_r == cvxh_pkg::ST_NEXT) begin
        k_r <= '0;
      end else if (push_ok) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      cvxh_pkg::ST_LOAD: begin
        if (load_last) begin
          n_r   <= n_tot;
          idx_r <= '0;
        end
      end
      cvxh_pkg::ST_LEFT: begin
        if (left_issue) idx_r <= idx_inc;
        rd_idx_r <= idx_r[cvxh_pkg::IDX_W-1:0];
        // strict less-than keeps the earliest point on equal x
        if (rd_vld_r && (rd_idx_r == '0 || st_x < px_r)) begin
          px_r    <= st_x;
          py_r    <= st_y;
          pidx_r  <= rd_idx_r;
          start_r <= rd_idx_r;
        end
      end
      cvxh_pkg::ST_REC: qidx_r <= q_start;
      cvxh_pkg::ST_QCAP: begin
        qx_r  <= st_x;
        qy_r  <= st_y;
        idx_r <= '0;
      end
      cvxh_pkg::ST_SC_MUL: begin
        ix_r   <= st_x;
        iy_r   <= st_y;
        iidx_r <= idx_r[cvxh_pkg::IDX_W-1:0];
      end
      cvxh_pkg::ST_SC_CMP: begin
        // collinear never replaces the candidate
        if (ccw) begin
          qx_r   <= ix_r;
          qy_r   <= iy_r;
          qidx_r <= iidx_r;
        end
        if (!cand_last) idx_r <= idx_inc;
      end
      cvxh_pkg::ST_NEXT: begin
        px_r   <= qx_r;
        py_r   <= qy_r;
        pidx_r <= qidx_r;
        jdx_r  <= '0;
      end
      cvxh_pkg::ST_H_PUSH: begin
        if (out_sts.can_push) begin
          if (hull_last) idx_r <= '0;
          else           jdx_r <= jdx_inc;
        end
      end
      cvxh_pkg::ST_I_CAP: begin
        cx_r  <= st_x;
        cy_r  <= st_y;
        hit_r <= 1'b0;
        jdx_r <= '0;
      end
      cvxh_pkg::ST_I_CMP: begin
        if (!hull_last) begin
          hit_r <= hit_any;
          jdx_r <= jdx_inc;
        end else if (hit_any || out_sts.can_push) begin
          idx_r <= idx_inc;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a new set only opens once every word of the previous one left the hold-back stage
  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_sts.pend_vld)
    else $error("input open while a result word is held back");

  a_hull_cap: assert property (@(posedge clk) disable iff (!rst_n)
    hlen_r <= cvxh_pkg::MAX_CNT)
    else $error("hull walk ran past its cap");

  a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cvxh_pkg::ST_SC_CMP) |-> ({1'b0, qidx_r} < n_r))
    else $error("hull candidate outside the loaded set");

  a_flush_tags_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cvxh_pkg::ST_FLUSH && out_sts.can_fin) |=>
      (state_r == cvxh_pkg::ST_LOAD && out_valid && out_data.end_of_run))
    else $error("closing word not tagged end of run");

endmodule

@@ dv/hull_result_checker.sv @@
// Channel monitor for the hull core: predicts every result word and scores the output channel.
module hull_result_checker
  import cvxh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_words
);

  logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
  logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
  int        pts_loaded;
  int        errs;
  out_item_t hull_words_due[$];
  out_item_t exp_w;

  // sign of the turn a -> b -> c; negative means counter-clockwise here
  function automatic longint turn_of(int a, int b, int c);
    return (longint'(pt_y[b]) - longint'(pt_y[a])) * (longint'(pt_x[c]) - longint'(pt_x[b]))
         - (longint'(pt_x[b]) - longint'(pt_x[a])) * (longint'(pt_y[c]) - longint'(pt_y[b]));
  endfunction

  // append one predicted word to the backlog
  function automatic void queue_word(out_item_t w);
    hull_words_due = {hull_words_due, w};
  endfunction

  function automatic void wrap_point_set(int n);
    int        start;
    int        p;
    int        q;
    int        hlen;
    int        k;
    int        walk [MAX_POINTS];
    bit        on_hull;
    out_item_t w;
    w = '0;
    if (n < int'(MIN_HULL_PTS)) begin
      w.point_kind = KIND_TOO_FEW;
      w.end_of_run = 1'b1;
      queue_word(w);
      return;
    end
    start = 0;
    for (int i = 1; i < n; i++)
      if (pt_x[i] < pt_x[start]) start = i;
    hlen = 0;
    p    = start;
    do begin
      walk[hlen] = p;
      hlen++;
      q = (p + 1) % n;
      for (int i = 0; i < n; i++)
        if (turn_of(p, i, q) < 0) q = i;
      p = q;
    end while (p != start && hlen < MAX_POINTS);
    k = 0;
    for (int j = 0; j < hlen && k < MAX_POINTS; j++) begin
      w.vert_x     = pt_x[walk[j]];
      w.vert_y     = pt_y[walk[j]];
      w.point_kind = KIND_HULL;
      queue_word(w);
      k++;
    end
    for (int i = 0; i < n && k < MAX_POINTS; i++) begin
      on_hull = 1'b0;
      for (int j = 0; j < hlen; j++)
        if (pt_x[i] == pt_x[walk[j]] && pt_y[i] == pt_y[walk[j]]) on_hull = 1'b1;
      if (!on_hull) begin
        w.vert_x     = pt_x[i];
        w.vert_y     = pt_y[i];
        w.point_kind = KIND_INTERIOR;
        queue_word(w);
        k++;
      end
    end
    hull_words_due[hull_words_due.size() - 1].end_of_run = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pts_loaded = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (pts_loaded < MAX_POINTS) begin
          pt_x[pts_loaded] = in_data.point_x;
          pt_y[pts_loaded] = in_data.point_y;
          pts_loaded++;
        end
        if (in_data.last_point) begin
          wrap_point_set(pts_loaded);
          pts_loaded = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (hull_words_due.size() == 0) begin
          $display("%0t: expected no word, actual x=%0d y=%0d kind=%0d end=%0d", $time,
                   out_data.vert_x, out_data.vert_y, out_data.point_kind, out_data.end_of_run);
          errs++;
        end else begin
          exp_w = hull_words_due.pop_front();
          if (out_data.vert_x !== exp_w.vert_x) begin
            $display("%0t: vert_x expected %0d actual %0d", $time, exp_w.vert_x, out_data.vert_x);
            errs++;
          end
          if (out_data.vert_y !== exp_w.vert_y) begin
            $display("%0t: vert_y expected %0d actual %0d", $time, exp_w.vert_y, out_data.vert_y);
            errs++;
          end
          if (out_data.point_kind !== exp_w.point_kind) begin
            $display("%0t: point_kind expected %0d actual %0d", $time,
                     exp_w.point_kind, out_data.point_kind);
            errs++;
          end
          if (out_data.end_of_run !== exp_w.end_of_run) begin
            $display("%0t: end_of_run expected %0d actual %0d", $time,
                     exp_w.end_of_run, out_data.end_of_run);
            errs++;
          end
        end
      end
    end
    fail_count    <= errs;
    pending_words <= hull_words_due.size();
  end

endmodule

@@ dv/convex_hull_gift_wrap_core_tb.sv @@
// Top-level bench for the gift-wrapping hull core: point-set stimulus, output back-pressure, verdict.
module convex_hull_gift_wrap_core_tb;
  import cvxh_pkg::*;

  // how the coordinates of a random point set are spread
  typedef enum int {
    SPREAD_FULL,   // anywhere in the 16-bit range
    SPREAD_TIGHT,  // a 4x4 patch: duplicates and collinear runs
    SPREAD_EDGE    // only the range limits, zero and the values next to zero
  } spread_t;

  localparam int RANDOM_WORDS = 187;
  localparam int QUIET_TAIL   = 40;   // last words go without any idling
  localparam int HOLD_CYCLES  = 300;  // one long receiver hold-off
  localparam int DRAIN_CYCLES = 100;
  localparam int BIG_SET      = MAX_POINTS + 2;  // overfills the point store

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int pending_words;
  int words_sent = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;

  always #2 clk = ~clk;

  convex_hull_gift_wrap_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  hull_result_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  function automatic logic signed [COORD_W-1:0] pick_coord(spread_t s);
    int r;
    case (s)
      SPREAD_TIGHT: begin
        r = int'($urandom_range(0, 3)) - 1;
        return COORD_W'(r);
      end
      SPREAD_EDGE: begin
        r = $urandom_range(0, 4);
        case (r)
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          3:       return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      default: return COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offers one point word and returns at the edge that accepts it. An idle burst,
  // if any, comes first, so valid never drops while a word is on offer. With no
  // burst the next call raises valid again in the same step, which keeps it high.
  task automatic send_word(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic last);
    in_item_t w;
    w.point_x    = x;
    w.point_y    = y;
    w.last_point = last;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_set(input int n, input spread_t s);
    for (int i = 0; i < n; i++)
      send_word(pick_coord(s), pick_coord(s), i == n - 1);
  endtask

  // Receiver: random stall bursts, ready stretches, and one long hold-off on request
  // while the sender keeps offering the next set.
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    int      target;
    int      pick;
    bit      big_done;
    big_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // too few points: a lone point at the range limits, then a pair
    send_word(16'sh7fff, 16'sh8000, 1'b1);
    send_word(16'sh8000, 16'sh7fff, 1'b0);
    send_word(16'sh0000, 16'shffff, 1'b1);

    // triangle spanning the full range; cross products need the wide math
    send_word(16'sh8000, 16'sh8000, 1'b0);
    send_word(16'sh7fff, 16'sh8000, 1'b0);
    send_word(16'sh0000, 16'sh7fff, 1'b1);

    // square with an interior point and a point on an edge (collinear candidate)
    send_word(16'sd0,  16'sd0,  1'b0);
    send_word(16'sd10, 16'sd0,  1'b0);
    send_word(16'sd10, 16'sd10, 1'b0);
    send_word(16'sd0,  16'sd10, 1'b0);
    send_word(16'sd5,  16'sd5,  1'b0);
    send_word(16'sd5,  16'sd0,  1'b1);
    // results of the square pile up behind a held receiver; next set waits on in_ready
    hold_req = 1'b1;

    // two points share the smallest x: the earlier one starts the walk
    send_word(-16'sd5, 16'sd3,  1'b0);
    send_word(-16'sd5, -16'sd3, 1'b0);
    send_word(16'sd2,  16'sd0,  1'b0);
    send_word(16'sd0,  16'sd0,  1'b1);

    // all points on one line
    send_word(16'sd1, 16'sd1, 1'b0);
    send_word(16'sd2, 16'sd2, 1'b0);
    send_word(16'sd3, 16'sd3, 1'b0);
    send_word(16'sd4, 16'sd4, 1'b1);

    // one point loaded three times
    send_word(16'sd7, 16'sd7, 1'b0);
    send_word(16'sd7, 16'sd7, 1'b0);
    send_word(16'sd7, 16'sd7, 1'b1);

    // random sets, mostly small; one overfills the store
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      quiet = (words_sent >= target - QUIET_TAIL);
      if (!big_done && words_sent >= target - RANDOM_WORDS + 60) begin
        send_set(BIG_SET, SPREAD_FULL);
        big_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_set($urandom_range(1, 2), SPREAD_FULL);
        else if (pick < 25)
          send_set($urandom_range(4, 20), SPREAD_TIGHT);
        else if (pick < 38)
          send_set($urandom_range(3, 8), SPREAD_EDGE);
        else
          send_set($urandom_range(3, 12), SPREAD_FULL);
      end
    end
    in_valid <= 1'b0;

    // let the checker see the final acceptance before reading its backlog
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog: far beyond the slowest legal run of this stimulus
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/cvxh_pkg.sv
rtl/core/cvxh_ram.sv
rtl/core/cvxh_orient.sv
rtl/core/cvxh_out.sv
rtl/core/convex_hull_gift_wrap_core.sv
dv/hull_result_checker.sv
dv/convex_hull_gift_wrap_core_tb.sv
